### rtl/htfd_pkg.sv
// Shared constants and types of the humidity and temperature frame decoder.
package htfd_pkg;

  // Frame byte positions; the position register holds the index of the next byte.
  localparam logic [2:0] POS_STATUS = 3'd0;
  localparam logic [2:0] POS_HUM_HI = 3'd1;
  localparam logic [2:0] POS_HUM_MID = 3'd2;
  localparam logic [2:0] POS_SPLIT = 3'd3;
  localparam logic [2:0] POS_TEMP_MID = 3'd4;
  localparam logic [2:0] POS_TEMP_LO = 3'd5;
  localparam logic [2:0] POS_CHECK = 3'd6;
  localparam logic [2:0] POS_IDLE = 3'd7;

  // CRC-8, MSB first, no reflection, no final xor.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Busy flag position in the status byte.
  localparam int unsigned BUSY_BIT = 7;

  // Fixed-point scale factors; products are taken >> 20.
  localparam logic [13:0] HUM_SCALE = 14'd10000;
  localparam logic [14:0] TEMP_SCALE = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_BUSY    = 2'd2
  } status_e;

endpackage

### rtl/humidity_temp_frame_decoder_unit.sv
// The check byte is registered at the input; its result item is then registered in the result register.
// One byte per cycle unless the sink stalls; a result item follows each frame's seventh byte.
// Timing is set by the input register and the result register around the CRC and multipliers.
// Reset: async active low; clears valids, sets byte position to 0 and CRC to 0xFF.
// After reset the first byte is taken as the status byte, with or without frame start.
module humidity_temp_frame_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] frame_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] frame_status, [21:2] humidity_raw, [41:22] temperature_raw,
  // [55:42] humidity_centi, [70:56] temperature_centi, [71] zero pad
  output logic [71:0] m_axis_tdata_o
);

  // ---------------------------------------------------------------------------
  // Input register: hold one item; refill whenever it moves on to the decode.
  // ---------------------------------------------------------------------------
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       advance;   // decode stage may move its item into the result reg
  logic       take_in;

  // The result register frees up when empty or when its item is taken.
  assign advance         = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign take_in         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take_in) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state: byte position, running CRC, busy flag and the two raw fields.
  // ---------------------------------------------------------------------------
  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_eff, crc_next;
  logic        busy_q, busy_d;
  logic [19:0] hum_q, hum_d;
  logic [19:0] temp_q, temp_d;
  logic        step;        // the decode stage consumes its item this cycle
  logic        emit;        // this item is the check byte of a frame

  assign step = in_valid_q && advance;

  // A start flag restarts the count and the CRC before the byte is handled.
  assign pos_eff = in_start_q ? htfd_pkg::POS_STATUS : pos_q;
  assign crc_eff = in_start_q ? htfd_pkg::CRC_INIT : crc_q;
  assign emit    = step && (pos_eff == htfd_pkg::POS_CHECK);

  htfd_crc8 u_crc8 (
    .crc_i  (crc_eff),
    .data_i (in_byte_q),
    .crc_o  (crc_next)
  );

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    busy_d = busy_q;
    hum_d  = hum_q;
    temp_d = temp_q;
    if (step) begin
      pos_d = pos_eff;
      crc_d = crc_eff;
      if (pos_eff < htfd_pkg::POS_CHECK) begin
        crc_d = crc_next;
        pos_d = pos_eff + 3'd1;
      end else if (pos_eff == htfd_pkg::POS_CHECK) begin
        // Frame done: go idle and drop bytes until the next start.
        pos_d = htfd_pkg::POS_IDLE;
      end
      case (pos_eff)
        htfd_pkg::POS_STATUS:   busy_d = in_byte_q[htfd_pkg::BUSY_BIT];
        htfd_pkg::POS_HUM_HI:   hum_d[19:12] = in_byte_q;
        htfd_pkg::POS_HUM_MID:  hum_d[11:4] = in_byte_q;
        htfd_pkg::POS_SPLIT: begin
          hum_d[3:0]    = in_byte_q[7:4];
          temp_d[19:16] = in_byte_q[3:0];
        end
        htfd_pkg::POS_TEMP_MID: temp_d[15:8] = in_byte_q;
        htfd_pkg::POS_TEMP_LO:  temp_d[7:0] = in_byte_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= htfd_pkg::POS_STATUS;
      crc_q  <= htfd_pkg::CRC_INIT;
      busy_q <= 1'b0;
      hum_q  <= '0;
      temp_q <= '0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      busy_q <= busy_d;
      hum_q  <= hum_d;
      temp_q <= temp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Check and convert: CRC mismatch wins over busy.
  // ---------------------------------------------------------------------------
  htfd_pkg::status_e  status;
  logic [13:0]        hum_centi;
  logic signed [14:0] temp_centi;

  always_comb begin
    if (crc_eff != in_byte_q) begin
      status = htfd_pkg::STATUS_CRC_ERR;
    end else if (busy_q) begin
      status = htfd_pkg::STATUS_BUSY;
    end else begin
      status = htfd_pkg::STATUS_OK;
    end
  end

  htfd_convert u_convert (
    .hum_raw_i    (hum_q),
    .temp_raw_i   (temp_q),
    .status_i     (status),
    .hum_centi_o  (hum_centi),
    .temp_centi_o (temp_centi)
  );

  // ---------------------------------------------------------------------------
  // Result register: load on the check byte, hold while the sink stalls.
  // ---------------------------------------------------------------------------
  logic        out_valid_q, out_valid_d;
  logic [71:0] out_data_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {1'b0, temp_centi, hum_centi, temp_q, hum_q, status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

### rtl/htfd_crc8.sv
// Byte-wide CRC-8 update, polynomial 0x31, MSB first.
module htfd_crc8 (
  input  logic [7:0] crc_i,
  input  logic [7:0] data_i,
  output logic [7:0] crc_o
);

  logic [7:0] c;

  always_comb begin
    c = crc_i ^ data_i;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

### rtl/htfd_convert.sv
// Conversion of raw humidity and temperature into hundredths, gated by status.
module htfd_convert (
  input  logic [19:0]          hum_raw_i,
  input  logic [19:0]          temp_raw_i,
  input  htfd_pkg::status_e    status_i,
  output logic [13:0]          hum_centi_o,
  output logic signed [14:0]   temp_centi_o
);

  logic [33:0] hum_prod;
  logic [34:0] temp_prod;
  logic [14:0] temp_scaled;

  assign hum_prod    = 34'(hum_raw_i) * 34'(htfd_pkg::HUM_SCALE);
  assign temp_prod   = 35'(temp_raw_i) * 35'(htfd_pkg::TEMP_SCALE);
  // Offset wraps in 15 bits, matching two's complement of the result range.
  assign temp_scaled = temp_prod[34:20] - htfd_pkg::TEMP_OFFSET;

  always_comb begin
    if (status_i == htfd_pkg::STATUS_OK) begin
      hum_centi_o  = hum_prod[33:20];
      temp_centi_o = temp_scaled;
    end else begin
      hum_centi_o  = '0;
      temp_centi_o = '0;
    end
  end

endmodule
